@@ rtl/cbcp_pkg.sv @@
// Shared types, address map constants and helpers for the CPU bus decoder
// with work RAM and controller ports. Used by every module in rtl/.
// No dependencies.
package cbcp_pkg;

	// Default work RAM depth in bytes
	localparam int RAM_DEPTH_DEF = 2048;

	// Highest address that maps to work RAM, and the width of that address window
	localparam logic [15:0] RAM_TOP  = 16'h1FFF;
	localparam int          RAM_AW   = 13;
	localparam logic [15:0] PPU_TOP  = 16'h3FFF;
	localparam logic [15:0] PPU_MASK = 16'h2007;

	// Register addresses in the I/O page
	localparam logic [15:0] APU_LAST    = 16'h4013;
	localparam logic [15:0] OAM_DMA     = 16'h4014;
	localparam logic [15:0] APU_STATUS  = 16'h4015;
	localparam logic [15:0] JOY_ONE     = 16'h4016;
	localparam logic [15:0] JOY_TWO     = 16'h4017;

	// Port byte layout
	localparam logic [7:0] OPEN_BUS_MASK = 8'hE0;
	localparam logic [7:0] GUN_TRIG_BIT  = 8'h10;
	localparam logic [7:0] GUN_DARK_BIT  = 8'h08;

	// Bus access kind
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Decoded destination of an access
	typedef enum logic [2:0] {
		TGT_UNMAPPED = 3'd0,
		TGT_RAM      = 3'd1,
		TGT_PPU      = 3'd2,
		TGT_APU      = 3'd3,
		TGT_PORT     = 3'd4,
		TGT_CART     = 3'd5,
		TGT_DMA      = 3'd6
	} target_t;

	// Work RAM command for one accepted item
	typedef struct packed {
		logic rd;
		logic wr;
	} ram_cmd_t;

	// Controller port request for one accepted item
	typedef struct packed {
		logic rd;        // serial read of a port
		logic port;      // 0 first port, 1 second port
		logic strobe_wr; // write of the strobe register
	} port_req_t;

	// Power-up contents of work RAM: all ones where index bit 2 is set
	function automatic logic [7:0] ram_fill(input logic idx_bit2);
		ram_fill = idx_bit2 ? 8'hFF : 8'h00;
	endfunction

endpackage

@@ rtl/cbcp_work_ram.sv @@
// Work RAM: single-port synchronous memory with a registered read and
// a power-up fill sweep. Depends on cbcp_pkg.
module cbcp_work_ram #(
	parameter int RAM_DEPTH = cbcp_pkg::RAM_DEPTH_DEF,
	localparam int IdxW = $clog2(RAM_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbcp_pkg::ram_cmd_t  cmd,
	input  logic [IdxW-1:0]     idx,
	input  logic [7:0]          wdata,
	output logic [7:0]          rdata,
	output logic                busy
);

	logic [7:0]      mem [RAM_DEPTH];
	logic [7:0]      rdata_q;
	logic            busy_q;
	logic [IdxW-1:0] fill_idx_q;
	logic [IdxW-1:0] wr_idx;
	logic [7:0]      wr_byte;
	logic            wr_en;

	// Fill sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			fill_idx_q <= '0;
		end else if (busy_q) begin
			fill_idx_q <= fill_idx_q + 1'b1;
			if (fill_idx_q == IdxW'(RAM_DEPTH - 1))
				busy_q <= 1'b0;
		end
	end

	// Write port shared by the sweep and bus writes
	always_comb begin
		if (busy_q) begin
			wr_idx  = fill_idx_q;
			wr_byte = cbcp_pkg::ram_fill(fill_idx_q[2]);
			wr_en   = 1'b1;
		end else begin
			wr_idx  = idx;
			wr_byte = wdata;
			wr_en   = cmd.wr;
		end
	end

	// Storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_byte;
		if (cmd.rd && !busy_q)
			rdata_q <= mem[idx];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

@@ rtl/cbcp_pad_ports.sv @@
// Two serial controller ports with strobe reload and one-fill, plus the
// light gun option on the second port. Depends on cbcp_pkg.
module cbcp_pad_ports (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  cbcp_pkg::port_req_t  req,
	input  logic [7:0]           write_data,
	input  logic [7:0]           open_bus_value,
	input  logic [7:0]           pad_one_buttons,
	input  logic [7:0]           pad_two_buttons,
	input  logic                 gun_light_seen,
	input  logic                 gun_trigger,
	input  logic                 cfg_wr,
	input  logic                 cfg_gun_en,
	output logic [7:0]           port_byte
);

	logic [7:0] shift_q [2];
	logic       strobe_q;
	logic       gun_en_q;
	logic [7:0] live;
	logic       gun_sel;
	logic       serial_bit;

	assign live       = req.port ? pad_two_buttons : pad_one_buttons;
	assign gun_sel    = req.port && gun_en_q;
	assign serial_bit = strobe_q ? live[7] : shift_q[req.port][7];

	// Byte returned for a port read
	always_comb begin
		if (gun_sel)
			port_byte = (open_bus_value & cbcp_pkg::OPEN_BUS_MASK)
				| (gun_trigger ? cbcp_pkg::GUN_TRIG_BIT : 8'h00)
				| (gun_light_seen ? 8'h00 : cbcp_pkg::GUN_DARK_BIT);
		else
			port_byte = (open_bus_value & cbcp_pkg::OPEN_BUS_MASK) | {7'd0, serial_bit};
	end

	// Shift registers, strobe and light gun enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			strobe_q   <= 1'b0;
			gun_en_q   <= 1'b0;
		end else begin
			if (cfg_wr)
				gun_en_q <= cfg_gun_en;
			if (accept && req.strobe_wr) begin
				strobe_q <= write_data[0];
				if (write_data[0]) begin
					shift_q[0] <= pad_one_buttons;
					shift_q[1] <= pad_two_buttons;
				end
			end else if (accept && req.rd && !gun_sel) begin
				if (strobe_q)
					shift_q[req.port] <= live;
				else
					shift_q[req.port] <= {shift_q[req.port][6:0], 1'b1};
			end
		end
	end

endmodule

@@ rtl/console_cpu_bus_and_controller_ports.sv @@
// CPU bus decoder with mirrored work RAM and two controller ports.
//
// Input channel: one bus access per item (op, address, write_data,
// open_bus_value, cart_claims, live pad and light gun inputs), taken at a
// clock edge with in_valid high and in_stall low. Output channel: one result
// item (read_data, target, device_address) per access, in order, taken at an
// edge with out_valid high and out_stall low.
// Configuration: light_gun_enable written through cfg_valid/cfg_ready,
// cfg_ready is always high; write it only while the block is idle.
// Pipeline: an access is registered into the decode stage, where its RAM
// read data lands alongside, then into the output register. Throughput: one
// item per clock while in_stall is low, set by the single work RAM port,
// which serves every access in its issue cycle, so no forwarding is needed.
// Reset: pad registers, strobe and light gun enable clear; the work RAM then
// runs a fill sweep over all RAM_DEPTH entries (2048 by default) during which
// in_stall is high. When out_stall holds the output register, one more item
// waits in the decode stage and in_stall rises.
// Depends on cbcp_pkg, cbcp_work_ram and cbcp_pad_ports.
module console_cpu_bus_and_controller_ports #(
	parameter int RAM_DEPTH = cbcp_pkg::RAM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        light_gun_enable,
	// access items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  open_bus_value,
	input  logic        cart_claims,
	input  logic [7:0]  pad_one_buttons,
	input  logic [7:0]  pad_two_buttons,
	input  logic        gun_light_seen,
	input  logic        gun_trigger,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [2:0]  target,
	output logic [15:0] device_address
);

	localparam int IdxW     = $clog2(RAM_DEPTH);
	localparam int MaxQuot  = (1 << cbcp_pkg::RAM_AW) / RAM_DEPTH;
	localparam int RemW     = cbcp_pkg::RAM_AW + 1;

	logic                accept;
	logic                ram_busy;
	logic [7:0]          ram_rdata;
	logic [7:0]          port_byte;
	cbcp_pkg::ram_cmd_t  ram_cmd;
	cbcp_pkg::port_req_t port_req;
	logic [RemW-1:0]     ram_rem;
	logic [IdxW-1:0]     ram_idx;
	logic                is_wr;

	logic [7:0]          data_c;
	cbcp_pkg::target_t   target_c;
	logic [15:0]         dev_c;

	logic                valid_s1;
	logic [7:0]          data_s1;
	cbcp_pkg::target_t   target_s1;
	logic [15:0]         dev_s1;
	logic                ram_sel_s1;
	logic                s1_move;

	logic                out_valid_q;
	logic [7:0]          read_data_q;
	cbcp_pkg::target_t   target_q;
	logic [15:0]         dev_q;

	// Handshakes
	assign s1_move   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = ram_busy || (valid_s1 && !s1_move);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign is_wr     = (op == cbcp_pkg::OP_WRITE);

	// Mirror fold: remainder of the RAM window address by the depth
	always_comb begin
		ram_rem = {1'b0, address[cbcp_pkg::RAM_AW-1:0]};
		for (int k = 1; k <= MaxQuot; k++) begin
			if ({1'b0, address[cbcp_pkg::RAM_AW-1:0]} >= RemW'(k * RAM_DEPTH))
				ram_rem = {1'b0, address[cbcp_pkg::RAM_AW-1:0]} - RemW'(k * RAM_DEPTH);
		end
	end
	assign ram_idx = ram_rem[IdxW-1:0];

	// Address decode
	always_comb begin
		data_c   = is_wr ? write_data : open_bus_value;
		target_c = cbcp_pkg::TGT_UNMAPPED;
		dev_c    = address;
		ram_cmd  = '0;
		port_req = '0;
		port_req.port = address[0];
		if (cart_claims) begin
			target_c = cbcp_pkg::TGT_CART;
		end else if (address <= cbcp_pkg::RAM_TOP) begin
			target_c   = cbcp_pkg::TGT_RAM;
			dev_c      = 16'(ram_idx);
			ram_cmd.wr = is_wr;
			ram_cmd.rd = !is_wr;
		end else if (address <= cbcp_pkg::PPU_TOP) begin
			target_c = cbcp_pkg::TGT_PPU;
			dev_c    = address & cbcp_pkg::PPU_MASK;
		end else if (!is_wr) begin
			if (address == cbcp_pkg::APU_STATUS) begin
				target_c = cbcp_pkg::TGT_APU;
			end else if (address == cbcp_pkg::JOY_ONE || address == cbcp_pkg::JOY_TWO) begin
				target_c    = cbcp_pkg::TGT_PORT;
				data_c      = port_byte;
				port_req.rd = 1'b1;
			end
		end else begin
			if (address == cbcp_pkg::OAM_DMA) begin
				target_c = cbcp_pkg::TGT_DMA;
			end else if (address <= cbcp_pkg::APU_LAST || address == cbcp_pkg::APU_STATUS
					|| address == cbcp_pkg::JOY_TWO) begin
				target_c = cbcp_pkg::TGT_APU;
			end else if (address == cbcp_pkg::JOY_ONE) begin
				target_c           = cbcp_pkg::TGT_PORT;
				port_req.strobe_wr = 1'b1;
			end
		end
	end

	cbcp_work_ram #(
		.RAM_DEPTH (RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (accept ? ram_cmd : '0),
		.idx    (ram_idx),
		.wdata  (write_data),
		.rdata  (ram_rdata),
		.busy   (ram_busy)
	);

	cbcp_pad_ports u_ports (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.req             (port_req),
		.write_data      (write_data),
		.open_bus_value  (open_bus_value),
		.pad_one_buttons (pad_one_buttons),
		.pad_two_buttons (pad_two_buttons),
		.gun_light_seen  (gun_light_seen),
		.gun_trigger     (gun_trigger),
		.cfg_wr          (cfg_valid && cfg_ready),
		.cfg_gun_en      (light_gun_enable),
		.port_byte       (port_byte)
	);

	// Decode stage valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (s1_move)
				valid_s1 <= 1'b0;
			if (s1_move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Decode stage payload, RAM read data lands alongside it
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1    <= data_c;
			target_s1  <= target_c;
			dev_s1     <= dev_c;
			ram_sel_s1 <= ram_cmd.rd;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_data_q <= ram_sel_s1 ? ram_rdata : data_s1;
			target_q    <= target_s1;
			dev_q       <= dev_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign target         = target_q;
	assign device_address = dev_q;

endmodule
